### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL; each check is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/tcsq_pkg.sv
package tcsq_pkg;

    // Fixed port widths of the item fields
    localparam int DATA_W   = 32;
    localparam int CLASS_W  = 2;
    localparam int STATUS_W = 2;
    // Number of per-class empty flags on the result port
    localparam int FLAG_CNT = 3;

    // Operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Memory strobes from the sequencer to the store
    typedef struct packed {
        logic link_rd;
        logic link_wr;
        logic ent_rd;
        logic ent_wr;
    } t_mem_ctl;

endpackage

### hw/rtl/three_class_shared_queue.sv
// Channel   Dir  Handshake                Fields
// input     in   i_in_valid / o_in_stall  i_kind, i_queue_class, i_payload
// result    out  o_out_valid / i_out_stall o_out_payload, o_status, o_class0_empty,
//                                         o_class1_empty, o_class2_empty, o_all_empty
//
// An item is taken in the idle state, which issues the link memory read and, for a
// dequeue, the entry memory read; the execute state then writes the link and entry
// memories as needed and loads the result, following the link read/write pass.
// Reset is synchronous; the free list needs no clearing pass,
// since never-used slots are handed out in order from a counter.
// A stalled result holds the execute state, so input stalls until it can be replaced.
module three_class_shared_queue #(
    parameter int CAPACITY      = 64,
    parameter int PAYLOAD_WIDTH = 32,
    parameter int NUM_CLASSES   = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_kind,
    input  logic [tcsq_pkg::CLASS_W-1:0]      i_queue_class,
    input  logic [tcsq_pkg::DATA_W-1:0]       i_payload,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [tcsq_pkg::DATA_W-1:0]       o_out_payload,
    output logic [tcsq_pkg::STATUS_W-1:0]     o_status,
    output logic                              o_class0_empty,
    output logic                              o_class1_empty,
    output logic                              o_class2_empty,
    output logic                              o_all_empty
);

    localparam int AW = $clog2(CAPACITY);
    localparam int SW = (PAYLOAD_WIDTH < tcsq_pkg::DATA_W) ? PAYLOAD_WIDTH
                        : tcsq_pkg::DATA_W;

    tcsq_pkg::t_mem_ctl mem_ctl;
    logic [AW-1:0]      link_rd_addr;
    logic [AW-1:0]      link_wr_addr;
    logic [AW-1:0]      link_wr_data;
    logic [AW-1:0]      ent_rd_addr;
    logic [AW-1:0]      ent_wr_addr;
    logic [SW-1:0]      ent_wr_data;
    logic [AW-1:0]      link_rd_data;
    logic [SW-1:0]      ent_rd_data;

    // List sequencer
    tcsq_ctrl #(
        .CAPACITY      (CAPACITY),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
        .NUM_CLASSES   (NUM_CLASSES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_queue_class  (i_queue_class),
        .i_payload      (i_payload),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_payload  (o_out_payload),
        .o_status       (o_status),
        .o_class0_empty (o_class0_empty),
        .o_class1_empty (o_class1_empty),
        .o_class2_empty (o_class2_empty),
        .o_all_empty    (o_all_empty),
        .o_mem_ctl      (mem_ctl),
        .o_link_rd_addr (link_rd_addr),
        .o_link_wr_addr (link_wr_addr),
        .o_link_wr_data (link_wr_data),
        .o_ent_rd_addr  (ent_rd_addr),
        .o_ent_wr_addr  (ent_wr_addr),
        .o_ent_wr_data  (ent_wr_data),
        .i_link_rd_data (link_rd_data),
        .i_ent_rd_data  (ent_rd_data)
    );

    // Shared entry and link store
    tcsq_store #(
        .CAPACITY (CAPACITY),
        .ENTRY_W  (SW)
    ) u_store (
        .i_clk          (i_clk),
        .i_ctl          (mem_ctl),
        .i_link_rd_addr (link_rd_addr),
        .i_link_wr_addr (link_wr_addr),
        .i_link_wr_data (link_wr_data),
        .i_ent_rd_addr  (ent_rd_addr),
        .i_ent_wr_addr  (ent_wr_addr),
        .i_ent_wr_data  (ent_wr_data),
        .o_link_rd_data (link_rd_data),
        .o_ent_rd_data  (ent_rd_data)
    );

endmodule

### hw/rtl/tcsq_store.sv
module tcsq_store #(
    parameter int CAPACITY = 64,
    parameter int ENTRY_W  = 32
) (
    input  logic                          i_clk,
    input  tcsq_pkg::t_mem_ctl            i_ctl,
    input  logic [$clog2(CAPACITY)-1:0]   i_link_rd_addr,
    input  logic [$clog2(CAPACITY)-1:0]   i_link_wr_addr,
    input  logic [$clog2(CAPACITY)-1:0]   i_link_wr_data,
    input  logic [$clog2(CAPACITY)-1:0]   i_ent_rd_addr,
    input  logic [$clog2(CAPACITY)-1:0]   i_ent_wr_addr,
    input  logic [ENTRY_W-1:0]            i_ent_wr_data,
    output logic [$clog2(CAPACITY)-1:0]   o_link_rd_data,
    output logic [ENTRY_W-1:0]            o_ent_rd_data
);

    localparam int AW = $clog2(CAPACITY);

    logic [AW-1:0]      r_link [CAPACITY];
    logic [ENTRY_W-1:0] r_ent  [CAPACITY];
    logic [AW-1:0]      r_link_rd;
    logic [ENTRY_W-1:0] r_ent_rd;

    // Link memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.link_wr) begin
            r_link[i_link_wr_addr] <= i_link_wr_data;
        end
        if (i_ctl.link_rd) begin
            r_link_rd <= r_link[i_link_rd_addr];
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.ent_wr) begin
            r_ent[i_ent_wr_addr] <= i_ent_wr_data;
        end
        if (i_ctl.ent_rd) begin
            r_ent_rd <= r_ent[i_ent_rd_addr];
        end
    end

    assign o_link_rd_data = r_link_rd;
    assign o_ent_rd_data  = r_ent_rd;

endmodule

### hw/rtl/tcsq_ctrl.sv
module tcsq_ctrl #(
    parameter int CAPACITY      = 64,
    parameter int PAYLOAD_WIDTH = 32,
    parameter int NUM_CLASSES   = 3
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input item channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_kind,
    input  logic [tcsq_pkg::CLASS_W-1:0]           i_queue_class,
    input  logic [tcsq_pkg::DATA_W-1:0]            i_payload,
    // result item channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [tcsq_pkg::DATA_W-1:0]            o_out_payload,
    output logic [tcsq_pkg::STATUS_W-1:0]          o_status,
    output logic                                   o_class0_empty,
    output logic                                   o_class1_empty,
    output logic                                   o_class2_empty,
    output logic                                   o_all_empty,
    // store port
    output tcsq_pkg::t_mem_ctl                     o_mem_ctl,
    output logic [$clog2(CAPACITY)-1:0]            o_link_rd_addr,
    output logic [$clog2(CAPACITY)-1:0]            o_link_wr_addr,
    output logic [$clog2(CAPACITY)-1:0]            o_link_wr_data,
    output logic [$clog2(CAPACITY)-1:0]            o_ent_rd_addr,
    output logic [$clog2(CAPACITY)-1:0]            o_ent_wr_addr,
    output logic [((PAYLOAD_WIDTH < tcsq_pkg::DATA_W) ? PAYLOAD_WIDTH
                   : tcsq_pkg::DATA_W)-1:0]        o_ent_wr_data,
    input  logic [$clog2(CAPACITY)-1:0]            i_link_rd_data,
    input  logic [((PAYLOAD_WIDTH < tcsq_pkg::DATA_W) ? PAYLOAD_WIDTH
                   : tcsq_pkg::DATA_W)-1:0]        i_ent_rd_data
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int TW  = CW + 1;
    localparam int CLW = $clog2(NUM_CLASSES);
    localparam int SW  = (PAYLOAD_WIDTH < tcsq_pkg::DATA_W) ? PAYLOAD_WIDTH
                         : tcsq_pkg::DATA_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // sequencer and captured item
    logic                          r_state, n_state;
    logic                          r_kind;
    logic [tcsq_pkg::CLASS_W-1:0]  r_cls;
    logic [SW-1:0]                 r_data;

    // list pointers and counts
    logic [AW-1:0] r_head [NUM_CLASSES];
    logic [AW-1:0] n_head [NUM_CLASSES];
    logic [AW-1:0] r_tail [NUM_CLASSES];
    logic [AW-1:0] n_tail [NUM_CLASSES];
    logic [CW-1:0] r_count [NUM_CLASSES];
    logic [CW-1:0] n_count [NUM_CLASSES];
    logic [AW-1:0] r_free_head, n_free_head;
    logic [CW-1:0] r_free_count, n_free_count;
    // slots at or above this mark have never been handed out
    logic [CW-1:0] r_fresh, n_fresh;

    // result register
    logic                              r_out_valid, n_out_valid;
    logic [tcsq_pkg::DATA_W-1:0]       r_out_payload, n_out_payload;
    logic [tcsq_pkg::STATUS_W-1:0]     r_status, n_status;
    logic [tcsq_pkg::FLAG_CNT-1:0]     r_flags, n_flags;
    logic                              r_all_empty, n_all_empty;

    logic          accept;
    logic          in_cls_ok;
    logic [AW-1:0] in_head;
    logic          exec_go;
    logic          cls_ok;
    logic [CLW-1:0] idx;
    logic [CW-1:0] cnt;
    logic [AW-1:0] cur_head;
    logic [AW-1:0] cur_tail;
    logic          enq_ok;
    logic          deq_ok;
    logic          head_fresh;
    logic [TW-1:0] total;

    // Issue memory reads as the item is taken
    assign accept     = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall = (r_state == S_EXEC);
    assign in_cls_ok  = int'(i_queue_class) < NUM_CLASSES;
    assign in_head    = in_cls_ok ? r_head[CLW'(i_queue_class)] : '0;

    assign o_link_rd_addr = (i_kind == tcsq_pkg::OP_DEQ) ? in_head : r_free_head;
    assign o_ent_rd_addr  = in_head;

    // Decode the held item
    assign exec_go    = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign cls_ok     = int'(r_cls) < NUM_CLASSES;
    assign idx        = CLW'(r_cls);
    assign cnt        = cls_ok ? r_count[idx] : '0;
    assign cur_head   = cls_ok ? r_head[idx] : '0;
    assign cur_tail   = cls_ok ? r_tail[idx] : '0;
    assign enq_ok     = (r_kind == tcsq_pkg::OP_ENQ) && cls_ok && (r_free_count != '0);
    assign deq_ok     = (r_kind == tcsq_pkg::OP_DEQ) && cls_ok && (cnt != '0);
    assign head_fresh = (CW'(r_free_head) == r_fresh);

    // Modify list state and write back
    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_free_head   = r_free_head;
        n_free_count  = r_free_count;
        n_fresh       = r_fresh;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_payload = '0;
        n_status      = tcsq_pkg::ST_OK;
        n_flags       = '1;
        n_all_empty   = 1'b0;

        o_mem_ctl.link_rd = accept;
        o_mem_ctl.ent_rd  = accept && (i_kind == tcsq_pkg::OP_DEQ);
        o_mem_ctl.link_wr = 1'b0;
        o_mem_ctl.ent_wr  = 1'b0;
        o_link_wr_addr    = cur_tail;
        o_link_wr_data    = r_free_head;
        o_ent_wr_addr     = r_free_head;
        o_ent_wr_data     = r_data;

        if (accept) begin
            n_state = S_EXEC;
        end

        if (exec_go) begin
            n_state     = S_IDLE;
            n_out_valid = 1'b1;
            if (enq_ok) begin
                // take a free slot, append it to the class list
                o_mem_ctl.ent_wr = 1'b1;
                if (head_fresh) begin
                    n_free_head = r_free_head + AW'(1);
                    n_fresh     = r_fresh + CW'(1);
                end else begin
                    n_free_head = i_link_rd_data;
                end
                n_free_count = r_free_count - CW'(1);
                if (cnt == '0) begin
                    n_head[idx] = r_free_head;
                end else begin
                    o_mem_ctl.link_wr = 1'b1;
                end
                n_tail[idx]  = r_free_head;
                n_count[idx] = cnt + CW'(1);
            end else if (deq_ok) begin
                // unlink the oldest entry and push its slot on the free list
                o_mem_ctl.link_wr = 1'b1;
                o_link_wr_addr    = cur_head;
                o_link_wr_data    = r_free_head;
                n_out_payload     = tcsq_pkg::DATA_W'(i_ent_rd_data);
                n_head[idx]       = i_link_rd_data;
                n_count[idx]      = cnt - CW'(1);
                n_free_head       = cur_head;
                n_free_count      = r_free_count + CW'(1);
            end else if (r_kind == tcsq_pkg::OP_DEQ) begin
                n_status = tcsq_pkg::ST_EMPTY;
            end else begin
                n_status = tcsq_pkg::ST_FULL;
            end

            for (int k = 0; k < tcsq_pkg::FLAG_CNT; k++) begin
                if (k < NUM_CLASSES) begin
                    n_flags[k] = (n_count[CLW'(k)] == '0);
                end
            end
            n_all_empty = (n_free_count == CW'(CAPACITY));
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_free_head  <= '0;
            r_free_count <= CW'(CAPACITY);
            r_fresh      <= '0;
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_head[k]  <= '0;
                r_tail[k]  <= '0;
                r_count[k] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_free_head  <= n_free_head;
            r_free_count <= n_free_count;
            r_fresh      <= n_fresh;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
        end
    end

    // Hold the taken item and the finished result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_cls  <= i_queue_class;
            r_data <= i_payload[SW-1:0];
        end
        if (exec_go) begin
            r_out_payload <= n_out_payload;
            r_status      <= n_status;
            r_flags       <= n_flags;
            r_all_empty   <= n_all_empty;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_payload  = r_out_payload;
    assign o_status       = r_status;
    assign o_class0_empty = r_flags[0];
    assign o_class1_empty = r_flags[1];
    assign o_class2_empty = r_flags[2];
    assign o_all_empty    = r_all_empty;

    // Occupancy over all lists, for checking only
    always_comb begin
        total = TW'(r_free_count);
        for (int k = 0; k < NUM_CLASSES; k++) begin
            total = total + TW'(r_count[k]);
        end
    end

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_slots_conserved, i_clk, i_rst_n, total == TW'(CAPACITY), "slot count mismatch")
    `ASSERT_ALWAYS(a_fresh_within_free, i_clk, i_rst_n, (CW'(CAPACITY) - r_fresh) <= r_free_count, "fresh slots exceed free count")
    `ASSERT_NEXT(a_enq_takes_slot, i_clk, i_rst_n, exec_go && enq_ok, r_free_count == $past(r_free_count) - CW'(1), "enqueue did not take a slot")
    `ASSERT_IMPLY(a_all_empty_flags, i_clk, i_rst_n, o_out_valid && o_all_empty, o_class0_empty && o_class1_empty && o_class2_empty, "all-empty with a busy class")
    `ASSERT_IMPLY(a_error_zero_data, i_clk, i_rst_n, o_out_valid && (o_status != tcsq_pkg::ST_OK), o_out_payload == '0, "error result carries data")

endmodule

### sim/three_class_shared_queue_tb.sv
`timescale 1ns / 100ps

module three_class_shared_queue_tb;

    localparam int SLOTS = 64;
    localparam int CLASSES = 3;
    localparam int BURST_LEN = 70;
    localparam logic [tcsq_pkg::CLASS_W-1:0] CLASS_ABSENT = 2'd3;

    typedef struct packed {
        logic [tcsq_pkg::DATA_W-1:0]   payload;
        logic [tcsq_pkg::STATUS_W-1:0] status;
        logic                          class0_empty;
        logic                          class1_empty;
        logic                          class2_empty;
        logic                          all_empty;
    } t_dequeue_result;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic                          in_kind = tcsq_pkg::OP_ENQ;
    logic [tcsq_pkg::CLASS_W-1:0]  in_class = '0;
    logic [tcsq_pkg::DATA_W-1:0]   in_payload = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [tcsq_pkg::DATA_W-1:0]   out_payload;
    logic [tcsq_pkg::STATUS_W-1:0] out_status;
    logic                          out_class0_empty;
    logic                          out_class1_empty;
    logic                          out_class2_empty;
    logic                          out_all_empty;

    // Shadow copy of the shared store: slot payloads, links, per-class lists
    logic [tcsq_pkg::DATA_W-1:0]   slot_data [SLOTS];
    int                            slot_next [SLOTS];
    int                            class_head [CLASSES];
    int                            class_tail [CLASSES];
    int                            class_fill [CLASSES];
    int                            free_head;
    int                            free_fill;

    t_dequeue_result               pending_results [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int results_checked = 0;
    int stored_cnt = 0;
    int removed_cnt = 0;
    int full_drop_cnt = 0;
    int absent_class_cnt = 0;
    int empty_read_cnt = 0;
    int peak_fill = 0;

    three_class_shared_queue dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_kind         (in_kind),
        .i_queue_class  (in_class),
        .i_payload      (in_payload),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_out_payload  (out_payload),
        .o_status       (out_status),
        .o_class0_empty (out_class0_empty),
        .o_class1_empty (out_class1_empty),
        .o_class2_empty (out_class2_empty),
        .o_all_empty    (out_all_empty)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Bring the shadow store to its post-reset state: free list runs 0,1,2,...
    function automatic void clear_store_model();
        for (int i = 0; i < SLOTS; i++) begin
            slot_data[i] = '0;
            slot_next[i] = (i + 1) % SLOTS;
        end
        for (int c = 0; c < CLASSES; c++) begin
            class_head[c] = 0;
            class_tail[c] = 0;
            class_fill[c] = 0;
        end
        free_head = 0;
        free_fill = SLOTS;
    endfunction

    // Apply one operation to the shadow store and return the result it gives
    function automatic t_dequeue_result apply_queue_op(
        logic op, logic [tcsq_pkg::CLASS_W-1:0] cls, logic [tcsq_pkg::DATA_W-1:0] data);
        t_dequeue_result res;
        int idx;
        res = '0;
        res.status = tcsq_pkg::ST_OK;
        if (op == tcsq_pkg::OP_ENQ) begin
            if (cls >= CLASSES || free_fill == 0) begin
                res.status = tcsq_pkg::ST_FULL;
                if (cls >= CLASSES) absent_class_cnt++;
                else full_drop_cnt++;
            end else begin
                idx = free_head;
                free_head = slot_next[idx];
                free_fill--;
                slot_data[idx] = data;
                if (class_fill[cls] == 0) class_head[cls] = idx;
                else slot_next[class_tail[cls]] = idx;
                class_tail[cls] = idx;
                class_fill[cls]++;
                stored_cnt++;
                if (SLOTS - free_fill > peak_fill) peak_fill = SLOTS - free_fill;
            end
        end else begin
            if (cls >= CLASSES || class_fill[cls] == 0) begin
                res.status = tcsq_pkg::ST_EMPTY;
                if (cls >= CLASSES) absent_class_cnt++;
                else empty_read_cnt++;
            end else begin
                idx = class_head[cls];
                res.payload = slot_data[idx];
                class_head[cls] = slot_next[idx];
                class_fill[cls]--;
                // freed slot goes to the front of the free list
                slot_next[idx] = free_head;
                free_head = idx;
                free_fill++;
                removed_cnt++;
            end
        end
        res.class0_empty = (class_fill[0] == 0);
        res.class1_empty = (class_fill[1] == 0);
        res.class2_empty = (class_fill[2] == 0);
        res.all_empty = (free_fill == SLOTS);
        return res;
    endfunction

    // Offer one item, with a random gap ahead of it, and hold it until accepted
    task automatic send_item(input logic op, input logic [tcsq_pkg::CLASS_W-1:0] cls,
                             input logic [tcsq_pkg::DATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_kind <= op;
        in_class <= cls;
        in_payload <= data;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_results.push_back(apply_queue_op(op, cls, data));
    endtask

    // Hold the input off until every outstanding result has come back
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    function automatic void check_field(string name, logic [tcsq_pkg::DATA_W-1:0] got,
                                        logic [tcsq_pkg::DATA_W-1:0] want);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each accepted result with the oldest prediction; randomise the stall
    always @(posedge clk) begin : check_results
        t_dequeue_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing outstanding: payload 0x%0h status %0d",
                       out_payload, out_status);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                check_field("out_payload", out_payload, want.payload);
                check_field("status", tcsq_pkg::DATA_W'(out_status),
                            tcsq_pkg::DATA_W'(want.status));
                check_field("class0_empty", tcsq_pkg::DATA_W'(out_class0_empty),
                            tcsq_pkg::DATA_W'(want.class0_empty));
                check_field("class1_empty", tcsq_pkg::DATA_W'(out_class1_empty),
                            tcsq_pkg::DATA_W'(want.class1_empty));
                check_field("class2_empty", tcsq_pkg::DATA_W'(out_class2_empty),
                            tcsq_pkg::DATA_W'(want.class2_empty));
                check_field("all_empty", tcsq_pkg::DATA_W'(out_all_empty),
                            tcsq_pkg::DATA_W'(want.all_empty));
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // FIFO order within a class, extreme payloads, and the store emptying out
    task automatic test_fifo_order();
        send_item(tcsq_pkg::OP_ENQ, 2'd0, 32'h0000_0000);
        send_item(tcsq_pkg::OP_ENQ, 2'd0, 32'hFFFF_FFFF);
        send_item(tcsq_pkg::OP_ENQ, 2'd1, 32'hA5A5_A5A5);
        send_item(tcsq_pkg::OP_ENQ, 2'd2, 32'h5A5A_5A5A);
        send_item(tcsq_pkg::OP_DEQ, 2'd0, 32'hFFFF_FFFF);
        send_item(tcsq_pkg::OP_DEQ, 2'd0, 32'h1234_5678);
        send_item(tcsq_pkg::OP_DEQ, 2'd0, 32'h0000_0000);
        send_item(tcsq_pkg::OP_DEQ, 2'd1, 32'h0000_0000);
        send_item(tcsq_pkg::OP_DEQ, 2'd2, 32'h0000_0000);
    endtask

    // Class number past the last class: always empty, enqueue dropped
    task automatic test_absent_class();
        send_item(tcsq_pkg::OP_ENQ, CLASS_ABSENT, 32'hDEAD_BEEF);
        send_item(tcsq_pkg::OP_DEQ, CLASS_ABSENT, 32'hFFFF_FFFF);
        send_item(tcsq_pkg::OP_DEQ, 2'd2, 32'h0000_0000);
    endtask

    // Removing the tail entry must leave the list ready for a fresh append
    task automatic test_tail_removal();
        send_item(tcsq_pkg::OP_ENQ, 2'd1, 32'h8000_0001);
        send_item(tcsq_pkg::OP_DEQ, 2'd1, 32'h0000_0000);
        send_item(tcsq_pkg::OP_ENQ, 2'd1, 32'h7FFF_FFFE);
        send_item(tcsq_pkg::OP_ENQ, 2'd1, 32'h0F0F_0F0F);
        send_item(tcsq_pkg::OP_ENQ, 2'd0, 32'hF0F0_F0F0);
        send_item(tcsq_pkg::OP_DEQ, 2'd1, 32'h0000_0000);
        send_item(tcsq_pkg::OP_ENQ, 2'd2, 32'h0000_0001);
        send_item(tcsq_pkg::OP_DEQ, 2'd1, 32'h0000_0000);
        send_item(tcsq_pkg::OP_DEQ, 2'd2, 32'h0000_0000);
        send_item(tcsq_pkg::OP_DEQ, 2'd0, 32'h0000_0000);
    endtask

    // Bursts biased to fill, mix and drain the store, so it hits full and empty
    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int enq_bias [5];
        logic op;
        logic [tcsq_pkg::CLASS_W-1:0] cls;
        logic [tcsq_pkg::DATA_W-1:0] data;
        enq_bias = '{85, 85, 50, 15, 15};
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int b = 0; b < 5; b++) begin
            for (int i = 0; i < BURST_LEN; i++) begin
                op = ($urandom_range(99) < enq_bias[b]) ? tcsq_pkg::OP_ENQ : tcsq_pkg::OP_DEQ;
                cls = ($urandom_range(19) == 0) ? CLASS_ABSENT
                      : tcsq_pkg::CLASS_W'($urandom_range(2));
                case ($urandom_range(7))
                    0: data = '0;
                    1: data = '1;
                    default: data = $urandom;
                endcase
                send_item(op, cls, data);
            end
        end
    endtask

    initial begin
        clear_store_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 31;
        recv_stall_pct = 87;
        test_fifo_order();
        test_absent_class();
        test_tail_removal();
        test_random_traffic(31, 87);
        wait_until_drained();
        test_random_traffic(87, 31);
        wait_until_drained();
        test_random_traffic(0, 0);
        wait_until_drained();
        repeat (8) @(posedge clk);

        $display("Ran %0d items: %0d stored, %0d removed, %0d dropped at full, %0d empty reads",
                 stored_cnt + removed_cnt + full_drop_cnt + empty_read_cnt + absent_class_cnt,
                 stored_cnt, removed_cnt, full_drop_cnt, empty_read_cnt);
        $display("Absent-class items %0d, peak occupancy %0d of %0d, %0d results compared",
                 absent_class_cnt, peak_fill, SLOTS, results_checked);
        if (fail_count == 0) begin
            $display("three_class_shared_queue verification clean");
        end else begin
            $display("three_class_shared_queue verification failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #5ms;
        $display("three_class_shared_queue verification failed");
        $finish;
    end

endmodule
